// ===== hdl/uec_pkg.sv =====
// ----------------------------------------------------------------------------
// uec_pkg
// Shared types, constants and calendar functions for the Unix time to civil
// date converter.
// ----------------------------------------------------------------------------
package uec_pkg;

    localparam int unsigned SECS_W    = 32;
    localparam int unsigned REM_W     = 17;
    localparam int unsigned DAYS_W    = 16;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned MDAY_W    = 5;
    localparam int unsigned HOUR_W    = 5;
    localparam int unsigned MIN_W     = 6;
    localparam int unsigned SEC_W     = 6;
    localparam int unsigned OUT_W     = 40;

    localparam logic [YEAR_W-1:0]  BASE_YEAR     = 12'd1970;
    localparam logic [YEAR_W-1:0]  LAST_YEAR     = 12'd2106;
    localparam logic [YEAR_W-1:0]  CENTURY_NOLEAP = 12'd2100;
    localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd11;
    localparam logic [MONTH_W-1:0] FEBRUARY      = 4'd1;

    // divide by the odd part of each length after dropping its power of two
    localparam logic [9:0]  DAY_ODD    = 10'd675;       // 86400 = 675 << 7
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [7:0]  HOUR_ODD   = 8'd225;        // 3600 = 225 << 4
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [3:0]  MIN_ODD    = 4'd15;         // 60 = 15 << 2
    localparam logic [11:0] MIN_RECIP  = 12'd2185;      // ceil(2^15 / 15)

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAYS,
        ST_LD_HOUR,
        ST_HOURS,
        ST_LD_MIN,
        ST_MINS,
        ST_CAL_INIT,
        ST_YEARS,
        ST_MONTHS,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     div_load;
        logic     div_step;
        div_sel_t div_sel;
        logic     cal_init;
        logic     year_step;
        logic     month_step;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_stall;
    } status_t;

    // years 1970..2106 only: of the century years, 2000 is leap, 2100 is not
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'd0) && (y != CENTURY_NOLEAP);
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [MDAY_W-1:0] len;
        unique case (m)
            FEBRUARY:            len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8,
            4'd10:               len = 5'd30;
            default:             len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/uec_ctrl.sv =====
// ----------------------------------------------------------------------------
// uec_ctrl
// Sequencer: runs the three division passes (quotient, then remainder), the
// year walk, the month walk and the hand-off to the output register.
// ----------------------------------------------------------------------------
module uec_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  uec_pkg::status_t status,
    output uec_pkg::cmd_t    cmd
);
    import uec_pkg::*;

    state_t            state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.div_sel    = DIV_DAY;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DAYS;
                end
            end
            ST_DAYS: begin
                cmd.div_step = 1'b1;
                state_next   = ST_LD_HOUR;
            end
            ST_LD_HOUR: begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_HOUR;
                state_next   = ST_HOURS;
            end
            ST_HOURS: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_HOUR;
                state_next   = ST_LD_MIN;
            end
            ST_LD_MIN: begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_MIN;
                state_next   = ST_MINS;
            end
            ST_MINS: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_MIN;
                state_next   = ST_CAL_INIT;
            end
            ST_CAL_INIT: begin
                cmd.cal_init = 1'b1;
                state_next   = ST_YEARS;
            end
            ST_YEARS: begin
                if (status.year_done) state_next = ST_MONTHS;
                else cmd.year_step = 1'b1;
            end
            ST_MONTHS: begin
                if (status.month_done) state_next = ST_EMIT;
                else cmd.month_step = 1'b1;
            end
            ST_EMIT: begin
                if (!status.out_stall) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.div_load, cmd.div_step, cmd.cal_init,
                  cmd.year_step, cmd.month_step, cmd.emit}))
        else $error("uec_ctrl: more than one datapath command");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !status.out_stall)
        else $error("uec_ctrl: result loaded over a stalled transfer");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_load && cmd.div_sel == DIV_DAY) |-> in_ready && in_valid)
        else $error("uec_ctrl: day pass started without an input transfer");

endmodule

// ===== hdl/uec_dp.sv =====
// ----------------------------------------------------------------------------
// uec_dp
// Datapath: reciprocal-multiply division by the day, hour and minute
// lengths, year and month walk, output register.
// ----------------------------------------------------------------------------
module uec_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [uec_pkg::SECS_W-1:0] secs_in,
    input  uec_pkg::cmd_t             cmd,
    output uec_pkg::status_t          status,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [uec_pkg::OUT_W-1:0] out_data
);
    import uec_pkg::*;

    logic [SECS_W-1:0]  num_reg, num_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   minute_reg, minute_next;
    logic [SEC_W-1:0]   second_reg, second_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic [24:0]        day_num;
    logic [50:0]        day_prod;
    logic [24:0]        day_back;
    logic [24:0]        day_left;
    logic [12:0]        hour_num;
    logic [26:0]        hour_prod;
    logic [12:0]        hour_back;
    logic [12:0]        hour_left;
    logic [9:0]         min_num;
    logic [21:0]        min_prod;
    logic [9:0]         min_back;
    logic [9:0]         min_left;
    logic               leap;
    logic [8:0]         ylen;
    logic [MDAY_W-1:0]  mlen;

    assign day_num   = num_reg[SECS_W-1:7];
    assign day_prod  = {26'd0, day_num} * {25'd0, DAY_RECIP};
    assign day_back  = {9'd0, days_reg} * {15'd0, DAY_ODD};
    assign day_left  = day_num - day_back;

    assign hour_num  = rem_reg[REM_W-1:4];
    assign hour_prod = {14'd0, hour_num} * {13'd0, HOUR_RECIP};
    assign hour_back = {8'd0, hour_reg} * {5'd0, HOUR_ODD};
    assign hour_left = hour_num - hour_back;

    assign min_num   = rem_reg[11:2];
    assign min_prod  = {12'd0, min_num} * {10'd0, MIN_RECIP};
    assign min_back  = {4'd0, minute_reg} * {6'd0, MIN_ODD};
    assign min_left  = min_num - min_back;

    assign leap  = is_leap(year_reg);
    assign ylen  = year_len(leap);
    assign mlen  = month_len(month_reg, leap);

    assign status.year_done  = (days_reg < {7'd0, ylen});
    assign status.month_done = (month_reg == LAST_MONTH) ||
                               (days_reg < {11'd0, mlen});
    assign status.out_stall  = out_valid_reg && !out_ready;

    always_comb begin
        num_next       = num_reg;
        rem_next       = rem_reg;
        days_next      = days_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.div_load) begin
            unique case (cmd.div_sel)
                DIV_HOUR: rem_next = {day_left[9:0], num_reg[6:0]};
                DIV_MIN:  rem_next = {5'd0, hour_left[7:0], rem_reg[3:0]};
                default:  num_next = secs_in;
            endcase
        end
        if (cmd.div_step) begin
            unique case (cmd.div_sel)
                DIV_HOUR: hour_next   = hour_prod[25:21];
                DIV_MIN:  minute_next = min_prod[20:15];
                default:  days_next   = day_prod[50:35];
            endcase
        end
        if (cmd.cal_init) begin
            second_next = {min_left[3:0], rem_reg[1:0]};
            year_next   = BASE_YEAR;
            month_next  = '0;
        end
        if (cmd.year_step) begin
            days_next = days_reg - {7'd0, ylen};
            year_next = year_reg + 12'd1;
        end
        if (cmd.month_step) begin
            days_next  = days_reg - {11'd0, mlen};
            month_next = month_reg + 4'd1;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {2'd0, second_reg, minute_reg, hour_reg,
                              days_reg[MDAY_W-1:0] + 5'd1,
                              month_reg + 4'd1, year_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else          out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge aclk) begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        days_reg     <= days_next;
        year_reg     <= year_next;
        month_reg    <= month_next;
        hour_reg     <= hour_next;
        minute_reg   <= minute_next;
        second_reg   <= second_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.year_step |-> (year_reg >= BASE_YEAR) && (year_reg < LAST_YEAR))
        else $error("uec_dp: year walk out of range");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.month_step |-> month_reg < LAST_MONTH)
        else $error("uec_dp: month walk past December");

    a_mday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> days_reg < 16'd31)
        else $error("uec_dp: day of month out of range");

endmodule

// ===== hdl/unix_epoch_to_calendar.sv =====
// ----------------------------------------------------------------------------
// unix_epoch_to_calendar
// Converts a 32-bit Unix time in seconds to UTC year, month, day, hour,
// minute and second.
//
//   channel  direction  tdata fields (lsb first)
//   s_       in         epoch_seconds[31:0]
//   m_       out        year[11:0] month[15:12] day[20:16] hour[25:21]
//                       minute[31:26] second[37:32], zero pad [39:38]
//
// One item at a time: after an input transfer the sequencer walks Y years
// and M months, Y = whole years since 1970 (0..136), M = month index (0..11).
// Each constant division takes a reciprocal multiply and then a remainder
// step; the year walk and the month walk follow before the result is valid.
// A new input is taken while a finished result still waits on m_tready.
// Synchronous active-low reset clears the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
module unix_epoch_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // year, month, day, hour, minute, second
);
    import uec_pkg::*;

    cmd_t    cmd;
    status_t status;

    uec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    uec_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .secs_in   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
